[hw/rtl/ewmamm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ewmamm_pkg
// Shared widths, reset values and register codes for the moving average
// block with aged minimum and maximum.
// ----------------------------------------------------------------------------
package ewmamm_pkg;

    localparam int SAMPLE_W             = 16;
    localparam int AVG_W                = 32;
    localparam int WEIGHT_W             = 16;
    localparam int AGE_W                = 5;
    localparam int COUNT_W              = 16;
    localparam int DEFAULT_WINDOW_DEPTH = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 16'h8000;
    localparam logic [AGE_W-1:0]    AGE_LIMIT_RESET = 5'd8;
    localparam logic [COUNT_W-1:0]  COUNT_MAX       = 16'hFFFF;

    // register codes, taken from paddr[2]
    localparam logic [0:0] REG_WEIGHT    = 1'b0;
    localparam logic [0:0] REG_AGE_LIMIT = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage
`default_nettype wire

[hw/rtl/ewmamm_win.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ewmamm_win
// Window store of earlier samples: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ewmamm_win
    import ewmamm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire sample_t       wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output sample_t            rd_data
);

    sample_t mem [WINDOW_DEPTH];
    sample_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[hw/rtl/ewma_with_aged_min_max.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ewma_with_aged_min_max
// Exponentially weighted moving average of signed samples with a tracked
// minimum and maximum that are rebuilt from a window of earlier samples
// once they have aged past a limit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  s_      | in        | s_valid / s_ready         | s_sample, s_first_sample
//  m_      | out       | m_valid / m_ready         | m_sample_index, m_value,
//          |           |                           | m_minimum, m_average, m_maximum
//  apb     | in        | psel, penable, pwrite     | paddr, pwdata, prdata
//
// An item passes through the states prep, scan and finish; the scan is
// skipped unless an extreme is due for a rescan. The rescan walks the
// window memory one entry per cycle through its single read port; minimum
// and maximum share one pass. Reset is synchronous and active low and
// needs no clearing pass. A result waiting on m_ready does not block the
// next item from being accepted; the item after that holds until it leaves.
// ----------------------------------------------------------------------------
module ewma_with_aged_min_max
    import ewmamm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    // input items
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sample_t             s_sample,
    input  wire logic                s_first_sample,
    // result items
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [COUNT_W-1:0]  m_sample_index,
    output sample_t                  m_value,
    output sample_t                  m_minimum,
    output logic signed [AVG_W-1:0]  m_average,
    output sample_t                  m_maximum
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int CW = (FW > AGE_W) ? FW : AGE_W;
    localparam int PA_W = WEIGHT_W + 2 + AVG_W;
    localparam int PB_W = WEIGHT_W + 1 + SAMPLE_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PREP   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [WEIGHT_W-1:0]     weight_reg;
    logic [AGE_W-1:0]        age_limit_reg;

    sample_t                 sample_reg;
    logic                    first_reg;
    sample_t                 min_value_reg, max_value_reg;
    logic [AGE_W-1:0]        min_age_reg, max_age_reg;
    logic signed [AVG_W-1:0] average_reg;
    logic [COUNT_W-1:0]      item_counter_reg;
    logic [FW-1:0]           fill_reg;
    logic [AW-1:0]           wp_reg;

    sample_t                 cand_min_reg, cand_max_reg;
    logic                    scan_min_reg, scan_max_reg;
    logic [FW-1:0]           remaining_reg;
    logic [AW-1:0]           rd_ptr_reg;
    logic signed [PA_W-1:0]  prod_a_reg;
    logic signed [PB_W-1:0]  prod_b_reg;

    logic                    m_valid_reg;
    logic [COUNT_W-1:0]      m_sample_index_reg;
    sample_t                 m_value_reg, m_minimum_reg, m_maximum_reg;
    logic signed [AVG_W-1:0] m_average_reg;

    // step preparation, valid in ST_PREP
    sample_t                 eff_min, eff_max;
    logic [AGE_W-1:0]        eff_min_age, eff_max_age;
    logic signed [AVG_W-1:0] eff_avg;
    logic [FW-1:0]           eff_fill;
    logic                    new_min, new_max, rescan_min, rescan_max;
    logic [CW-1:0]           lim_ext, fill_ext;
    logic [FW-1:0]           scan_count;
    logic [WEIGHT_W:0]       inv_weight;

    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    sample_t                 rd_data;
    logic                    wr_en;
    logic                    can_load;
    logic [PA_W-1:0]         avg_sum;
    logic [AVG_W-1:0]        avg_new;

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(WINDOW_DEPTH - 1) : p - AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg    <= WEIGHT_RESET;
            age_limit_reg <= AGE_LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_WEIGHT) begin
                weight_reg <= pwdata[WEIGHT_W-1:0];
            end else begin
                age_limit_reg <= pwdata[AGE_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WEIGHT:    prdata = {{(32-WEIGHT_W){1'b0}}, weight_reg};
            REG_AGE_LIMIT: prdata = {{(32-AGE_W){1'b0}}, age_limit_reg};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // step preparation: a new data set overrides the held state
    // ------------------------------------------------------------------
    always_comb begin
        eff_min     = first_reg ? sample_reg : min_value_reg;
        eff_max     = first_reg ? sample_reg : max_value_reg;
        eff_min_age = first_reg ? '0 : min_age_reg;
        eff_max_age = first_reg ? '0 : max_age_reg;
        eff_fill    = first_reg ? '0 : fill_reg;
        eff_avg     = first_reg ? {sample_reg, {(AVG_W-SAMPLE_W){1'b0}}} : average_reg;

        new_min    = sample_reg < eff_min;
        new_max    = sample_reg > eff_max;
        rescan_min = !new_min && (eff_min_age >= age_limit_reg);
        rescan_max = !new_max && (eff_max_age >= age_limit_reg);

        lim_ext  = (age_limit_reg == '0) ? '0 : CW'(age_limit_reg - AGE_W'(1));
        fill_ext = CW'(eff_fill);
        if (!(rescan_min || rescan_max)) begin
            scan_count = '0;
        end else if (lim_ext < fill_ext) begin
            scan_count = FW'(lim_ext);
        end else begin
            scan_count = eff_fill;
        end

        inv_weight = (WEIGHT_W+1)'(17'h10000 - {1'b0, weight_reg});
    end

    // ------------------------------------------------------------------
    // window memory
    // ------------------------------------------------------------------
    assign rd_addr  = (state_reg == ST_PREP) ? ptr_dec(wp_reg) : ptr_dec(rd_ptr_reg);
    assign rd_en    = ((state_reg == ST_PREP) && (scan_count != '0))
                   || ((state_reg == ST_SCAN) && (remaining_reg > FW'(1)));
    assign can_load = !m_valid_reg || m_ready;
    assign wr_en    = (state_reg == ST_FINISH) && can_load;

    ewmamm_win #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_win (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // rounding: halves go toward plus infinity
    assign avg_sum = PA_W'(prod_a_reg)
                   + PA_W'({prod_b_reg, {WEIGHT_W{1'b0}}})
                   + PA_W'(32'h8000);
    assign avg_new = avg_sum[AVG_W+WEIGHT_W-1:WEIGHT_W];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = (scan_count != '0) ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
                if (remaining_reg <= FW'(1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (can_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            min_value_reg    <= '0;
            max_value_reg    <= '0;
            min_age_reg      <= '0;
            max_age_reg      <= '0;
            average_reg      <= '0;
            item_counter_reg <= '0;
            fill_reg         <= '0;
            wp_reg           <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_PREP) begin
                min_age_reg <= (new_min || rescan_min) ? '0 : eff_min_age + AGE_W'(1);
                max_age_reg <= (new_max || rescan_max) ? '0 : eff_max_age + AGE_W'(1);
                fill_reg    <= eff_fill;
                if (first_reg) begin
                    item_counter_reg <= COUNT_W'(1);
                end else if (item_counter_reg != COUNT_MAX) begin
                    item_counter_reg <= item_counter_reg + COUNT_W'(1);
                end
            end

            if (wr_en) begin
                min_value_reg <= cand_min_reg;
                max_value_reg <= cand_max_reg;
                average_reg   <= avg_new;
                wp_reg        <= ptr_inc(wp_reg);
                if (fill_reg != FW'(WINDOW_DEPTH)) begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end

            if (wr_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            sample_reg <= s_sample;
            first_reg  <= s_first_sample;
        end

        if (state_reg == ST_PREP) begin
            cand_min_reg  <= (new_min || rescan_min) ? sample_reg : eff_min;
            cand_max_reg  <= (new_max || rescan_max) ? sample_reg : eff_max;
            scan_min_reg  <= rescan_min;
            scan_max_reg  <= rescan_max;
            remaining_reg <= scan_count;
            prod_a_reg    <= $signed({1'b0, inv_weight}) * eff_avg;
            prod_b_reg    <= $signed({1'b0, weight_reg}) * sample_reg;
        end

        if (rd_en) begin
            rd_ptr_reg <= rd_addr;
        end

        // walk back through earlier samples of this data set
        if (state_reg == ST_SCAN) begin
            remaining_reg <= remaining_reg - FW'(1);
            if (scan_min_reg && (rd_data < cand_min_reg)) begin
                cand_min_reg <= rd_data;
            end
            if (scan_max_reg && (rd_data > cand_max_reg)) begin
                cand_max_reg <= rd_data;
            end
        end

        if (wr_en) begin
            m_sample_index_reg <= item_counter_reg;
            m_value_reg        <= sample_reg;
            m_minimum_reg      <= cand_min_reg;
            m_maximum_reg      <= cand_max_reg;
            m_average_reg      <= avg_new;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_sample_index = m_sample_index_reg;
    assign m_value        = m_value_reg;
    assign m_minimum      = m_minimum_reg;
    assign m_average      = m_average_reg;
    assign m_maximum      = m_maximum_reg;

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ewma_with_aged_min_max: drives sample items over
// valid/ready, writes and reads back the weight and age limit over APB, and
// compares every result field against a cycle-free predictor of the average,
// the aged extremes and the index count.
// ----------------------------------------------------------------------------
module testbench;
    import ewmamm_pkg::*;

    localparam int WINDOW        = DEFAULT_WINDOW_DEPTH;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 160;

    localparam logic [2:0] WEIGHT_ADDR    = {REG_WEIGHT, 2'b00};
    localparam logic [2:0] AGE_LIMIT_ADDR = {REG_AGE_LIMIT, 2'b00};

    typedef struct {
        sample_t sample;
        logic    first;
    } sample_item_t;

    typedef struct {
        logic [COUNT_W-1:0]      index;
        sample_t                 value;
        sample_t                 minimum;
        logic signed [AVG_W-1:0] average;
        sample_t                 maximum;
    } ewma_result_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic    s_valid        = 1'b0;
    logic    s_ready;
    sample_t s_sample       = '0;
    logic    s_first_sample = 1'b0;

    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [COUNT_W-1:0]      m_sample_index;
    sample_t                 m_value;
    sample_t                 m_minimum;
    logic signed [AVG_W-1:0] m_average;
    sample_t                 m_maximum;

    ewma_with_aged_min_max dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_first_sample (s_first_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_index (m_sample_index),
        .m_value        (m_value),
        .m_minimum      (m_minimum),
        .m_average      (m_average),
        .m_maximum      (m_maximum)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // predictor state and its copy of the registers
    int mix_weight    = WEIGHT_RESET;
    int age_limit_cfg = AGE_LIMIT_RESET;
    int win_mem [WINDOW];
    int win_ptr       = 0;
    int win_fill      = 0;
    int trk_min       = 0;
    int trk_max       = 0;
    int min_age       = 0;
    int max_age       = 0;
    int avg_q16       = 0;
    int set_count     = 0;

    sample_item_t pending_samples[$];
    ewma_result_t expected_results[$];
    sample_item_t next_item;
    ewma_result_t oldest_result;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  pressure_on    = 1'b0;
    int  hold_count     = 0;
    int  error_count    = 0;
    int  cycle_count    = 0;

    // best value over the current sample and the earlier samples of this set
    function automatic int rescan_window(int current, bit want_max);
        int best;
        int idx;
        best = current;
        for (int y = 1; y < age_limit_cfg && y <= win_fill; y++) begin
            idx = (win_ptr + WINDOW - y) % WINDOW;
            if (want_max ? (win_mem[idx] > best) : (win_mem[idx] < best))
                best = win_mem[idx];
        end
        return best;
    endfunction

    function automatic ewma_result_t predict_ewma_step(sample_t sample, logic first);
        ewma_result_t r;
        longint       acc;
        int           s;
        s = sample;
        if (first) begin
            trk_min   = s;
            trk_max   = s;
            min_age   = 0;
            max_age   = 0;
            win_fill  = 0;
            avg_q16   = s * 65536;
            set_count = 1;
        end else if (set_count < COUNT_MAX) begin
            set_count++;
        end

        if (s < trk_min) begin
            trk_min = s;
            min_age = 0;
        end else if (min_age >= age_limit_cfg) begin
            trk_min = rescan_window(s, 1'b0);
            min_age = 0;
        end else begin
            min_age++;
        end

        if (s > trk_max) begin
            trk_max = s;
            max_age = 0;
        end else if (max_age >= age_limit_cfg) begin
            trk_max = rescan_window(s, 1'b1);
            max_age = 0;
        end else begin
            max_age++;
        end

        // round half up, then floor via arithmetic shift
        acc = longint'(mix_weight) * longint'(s) * 64'sd65536
            + longint'(65536 - mix_weight) * longint'(avg_q16) + 64'sd32768;
        avg_q16 = int'(acc >>> 16);

        win_mem[win_ptr] = s;
        win_ptr = (win_ptr + 1) % WINDOW;
        if (win_fill < WINDOW)
            win_fill++;

        r.index   = set_count[COUNT_W-1:0];
        r.value   = sample;
        r.minimum = trk_min[SAMPLE_W-1:0];
        r.average = avg_q16;
        r.maximum = trk_max[SAMPLE_W-1:0];
        return r;
    endfunction

    // driver: predict on acceptance, then offer the next item or go idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(predict_ewma_step(s_sample, s_first_sample));
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_samples.pop_front();
                    s_valid        <= 1'b1;
                    s_sample       <= next_item.sample;
                    s_first_sample <= next_item.first;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long hold-off, counted once
    always @(posedge aclk) begin
        if (pressure_on && hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !(pressure_on && hold_count < HOLD_CYCLES)
                       && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: expected none, got index %0d",
                         $time, m_sample_index);
            end else begin
                oldest_result = expected_results.pop_front();
                check_field("sample_index", oldest_result.index, m_sample_index);
                check_field("value", oldest_result.value, m_value);
                check_field("minimum", oldest_result.minimum, m_minimum);
                check_field("average", oldest_result.average, m_average);
                check_field("maximum", oldest_result.maximum, m_maximum);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic check_register(logic [2:0] addr, logic [31:0] want, int width);
        logic [31:0] mask;
        mask = (32'd1 << width) - 32'd1;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        // sample mid access phase
        @(negedge aclk);
        if (((prdata ^ want) & mask) != 32'd0) begin
            error_count++;
            $display("%0t: register %0d readback mismatch: expected %0d, got %0d",
                     $time, addr, want & mask, prdata & mask);
        end
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_register(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == WEIGHT_ADDR) begin
            mix_weight = value[WEIGHT_W-1:0];
            check_register(addr, value, WEIGHT_W);
        end else begin
            age_limit_cfg = value[AGE_W-1:0];
            check_register(addr, value, AGE_W);
        end
    endtask

    task automatic push_item(int value, bit first);
        sample_item_t it;
        it.sample = sample_t'(value);
        it.first  = first;
        pending_samples.push_back(it);
    endtask

    function automatic int make_sample(int style, int base, int step, int pos);
        int v;
        case (style)
            0: begin
                v = $urandom_range(65535) - 32768;
            end
            1: begin
                v = base + $urandom_range(128) - 64;
            end
            2: begin
                v = base + pos * step;
            end
            default: begin
                if ($urandom_range(7) == 0)
                    v = $urandom_range(1) ? 32767 : -32768;
                else
                    v = base + $urandom_range(2000) - 1000;
            end
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // data sets of random shape; some carry on from the previous set
    task automatic add_random_sets(int n_items, bit continue_first);
        int  added;
        int  len;
        int  pick;
        int  style;
        int  base;
        int  step;
        bit  opens;
        added = 0;
        while (added < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(24, 1);
            else if (pick < 95)
                len = $urandom_range(60, 25);
            else
                len = $urandom_range(3, 1);
            style = $urandom_range(3);
            base  = $urandom_range(65535) - 32768;
            step  = $urandom_range(400) - 200;
            opens = !(added == 0 && continue_first) && ($urandom_range(9) != 0);
            for (int k = 0; k < len && added < n_items; k++) begin
                push_item(make_sample(style, base, step, k), opens && k == 0);
                added++;
            end
        end
    endtask

    task automatic drain;
        while (pending_samples.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int w;
        int lim;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_register(WEIGHT_ADDR, WEIGHT_RESET, WEIGHT_W);
        check_register(AGE_LIMIT_ADDR, AGE_LIMIT_RESET, AGE_W);

        send_idle_pct  <= 25;
        recv_stall_pct <= 25;
        // steps before any data set has started
        push_item(0, 1'b0);
        push_item(-5, 1'b0);
        push_item(7, 1'b0);
        // field extremes
        push_item(32767, 1'b1);
        push_item(-32768, 1'b0);
        push_item(32767, 1'b0);
        push_item(0, 1'b0);
        push_item(-32768, 1'b1);
        // hold a stale maximum until it ages out and is rescanned
        push_item(100, 1'b1);
        push_item(200, 1'b0);
        for (int k = 0; k < 9; k++)
            push_item(150 - k, 1'b0);
        drain();

        // zero age limit: rescan on every step that brings no new extreme
        set_register(WEIGHT_ADDR, 32'd0);
        set_register(AGE_LIMIT_ADDR, 32'd0);
        push_item(5, 1'b1);
        push_item(3, 1'b0);
        push_item(4, 1'b0);
        push_item(9, 1'b0);
        push_item(1, 1'b0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            w = $urandom_range(65535);
            case (p)
                0: begin
                    w = 0;
                    lim = 0;
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    w = 65535;
                    lim = 31;
                    send_idle_pct  <= 47;
                    recv_stall_pct <= 0;
                end
                2: begin
                    // lower the limit under ages left over from the last phase
                    w = 1;
                    lim = 1;
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 47;
                end
                3: begin
                    lim = 16;
                    send_idle_pct  <= 25;
                    recv_stall_pct <= 25;
                end
                4: begin
                    w = 32768;
                    lim = 2;
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                    pressure_on    <= 1'b1;
                end
                default: begin
                    lim = $urandom_range(1) ? 17 : $urandom_range(31);
                    send_idle_pct  <= 25;
                    recv_stall_pct <= 25;
                end
            endcase
            set_register(WEIGHT_ADDR, w);
            set_register(AGE_LIMIT_ADDR, lim);
            add_random_sets(PHASE_ITEMS, 1'b1);
            drain();
            pressure_on <= 1'b0;
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
